// ===== hdl/cdd_pkg.sv =====
// Shared types, constants and calendar functions for the date decrement block.
package cdd_pkg;

	localparam int COUNT_BITS_DEF = 12;
	localparam int STEP_W         = 12;

	// operation codes
	localparam logic [2:0] OP_DAYS      = 3'd0;
	localparam logic [2:0] OP_WEEKS     = 3'd1;
	localparam logic [2:0] OP_MONTHS    = 3'd2;
	localparam logic [2:0] OP_YEARS     = 3'd3;
	localparam logic [2:0] OP_DECADES   = 3'd4;
	localparam logic [2:0] OP_CENTURIES = 3'd5;
	localparam logic [2:0] OP_MILLENNIA = 3'd6;

	// y mod 400 by reciprocal: q = (u * RECIP_400) >> RECIP_SHIFT, exact for 16-bit u
	localparam logic [16:0] RECIP_400   = 17'd83887;
	localparam int          RECIP_SHIFT = 25;
	localparam logic [8:0]  BIAS_RESID  = 9'd368;  // 32768 mod 400
	localparam logic [8:0]  WRAP_RESID  = 9'd367;  // 32767 mod 400
	localparam logic [8:0]  LAST_RESID  = 9'd399;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_RESID,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic [8:0]  resid;  // year mod 400, mathematical residue
	} date_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		begin
			unique case (m)
				4'd2: len = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

	function automatic logic [16:0] year_scale(input logic [2:0] op);
		logic [16:0] k;
		begin
			unique case (op)
				OP_DECADES:   k = 17'd10;
				OP_CENTURIES: k = 17'd100;
				OP_MILLENNIA: k = 17'd1000;
				default:      k = 17'd1;
			endcase
			return k;
		end
	endfunction

endpackage

// ===== hdl/cdd_mult.sv =====
// Shared registered multiplier: year scaling and the mod-400 reciprocal product.
module cdd_mult (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] a,
	input  logic [16:0] b,
	output logic [32:0] prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {17'd0, a} * {16'd0, b};
		end
	end

endmodule

// ===== hdl/cdd_step_unit.sv =====
// One calendar step back: either one day or one month, with leap-year handling.
module cdd_step_unit (
	input  logic            month_mode,
	input  cdd_pkg::date_t  cur,
	output cdd_pkg::date_t  nxt
);

	logic        leap;
	logic [3:0]  prev_m;
	logic [4:0]  len;
	logic [15:0] y_dec;
	logic [8:0]  r_dec;

	always_comb begin
		leap   = (cur.year[1:0] == 2'b00) && (cur.resid != 9'd100) &&
		         (cur.resid != 9'd200) && (cur.resid != 9'd300);
		prev_m = cur.month - 4'd1;
		len    = cdd_pkg::month_days(prev_m, leap);
		y_dec  = cur.year - 16'd1;
		// residue follows the 16-bit wrap from -32768 to 32767
		if (cur.year == 16'h8000) begin
			r_dec = cdd_pkg::WRAP_RESID;
		end else if (cur.resid == 9'd0) begin
			r_dec = cdd_pkg::LAST_RESID;
		end else begin
			r_dec = cur.resid - 9'd1;
		end

		nxt = cur;
		if (month_mode) begin
			if (cur.month == 4'd1) begin
				nxt.month = 4'd12;
				nxt.year  = y_dec;
				nxt.resid = r_dec;
			end else begin
				nxt.month = prev_m;
				if (cur.day > len) begin
					nxt.day = len;
				end
			end
		end else begin
			if (cur.day > 5'd1) begin
				nxt.day = cur.day - 5'd1;
			end else if (cur.month == 4'd1) begin
				nxt.day   = 5'd31;
				nxt.month = 4'd12;
				nxt.year  = y_dec;
				nxt.resid = r_dec;
			end else begin
				nxt.day   = len;
				nxt.month = prev_m;
			end
		end
	end

endmodule

// ===== hdl/calendar_date_decrement.sv =====
// Gregorian date decrement: sequencer around a shared multiplier and a one-step calendar unit.
//
//  channel | dir | signals                         | contents
//  s_      | in  | tvalid tready tdata[39:0] tuser | date, count, operation
//  m_      | out | tvalid tready tdata[31:0]       | resulting date
//
// Day/week/month ops: after the multiplier pass, N steps (N = count, times 7 for weeks), one calendar
// step per cycle through the step unit; year-type ops skip stepping, and an invalid op goes straight to done.
// The multiplier first forms y mod 400 (leap tracking) or count times scale.
// arst_n clears the sequencer; s_tready is low from accept until the result transfer.
// The result is held on m_tdata while m_tready is low.
module calendar_date_decrement #(
	parameter int COUNT_BITS = cdd_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // step_count[11:0], day_in[16:12], month_in[20:17],
	                               // year_in[36:21], zero pad [39:37]
	input  logic [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // day_out[4:0], month_out[8:5], year_out[24:9], pad
);

	localparam int CW  = (COUNT_BITS < cdd_pkg::STEP_W) ? COUNT_BITS : cdd_pkg::STEP_W;
	localparam int CNT = CW + 3;

	cdd_pkg::state_t state_q, state_d;
	cdd_pkg::date_t  date_q, date_step;
	logic [2:0]      op_q;
	logic [CNT-1:0]  cnt_q;
	logic [CW-1:0]   n_in;
	logic [4:0]      day_in;
	logic [3:0]      month_in;
	logic            accept, year_op, mult_en;
	logic [15:0]     mul_a, u;
	logic [16:0]     mul_b, q400, r_raw;
	logic [32:0]     prod_q;
	logic [7:0]      q;
	logic [8:0]      r;

	assign accept      = s_tvalid && s_tready;
	assign n_in        = s_tdata[CW-1:0];
	assign year_op     = (op_q == cdd_pkg::OP_YEARS) || (op_q == cdd_pkg::OP_DECADES) ||
	                     (op_q == cdd_pkg::OP_CENTURIES) || (op_q == cdd_pkg::OP_MILLENNIA);

	always_comb begin
		day_in   = (s_tdata[16:12] == 5'd0) ? 5'd1 : s_tdata[16:12];
		month_in = s_tdata[20:17];
		if (month_in == 4'd0) begin
			month_in = 4'd1;
		end else if (month_in > 4'd12) begin
			month_in = 4'd12;
		end
	end

	// offset-binary year so the reciprocal works on an unsigned value
	assign u     = {~date_q.year[15], date_q.year[14:0]};
	assign mul_a = year_op ? {{(16-CNT){1'b0}}, cnt_q} : u;
	assign mul_b = year_op ? cdd_pkg::year_scale(op_q) : cdd_pkg::RECIP_400;
	assign mult_en = (state_q == cdd_pkg::ST_MULT);

	cdd_mult u_mult (
		.clk    (clk),
		.en     (mult_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	cdd_step_unit u_step (
		.month_mode (op_q == cdd_pkg::OP_MONTHS),
		.cur        (date_q),
		.nxt        (date_step)
	);

	always_comb begin
		q     = prod_q[cdd_pkg::RECIP_SHIFT +: 8];
		q400  = {1'b0, q, 8'd0} + {2'b0, q, 7'd0} + {5'b0, q, 4'd0};
		r_raw = {1'b0, u} - q400;
		r     = (r_raw[8:0] >= cdd_pkg::BIAS_RESID) ? (r_raw[8:0] - cdd_pkg::BIAS_RESID)
		                                             : (r_raw[8:0] + 9'd32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			cdd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser > cdd_pkg::OP_MILLENNIA) ? cdd_pkg::ST_DONE
					                                             : cdd_pkg::ST_MULT;
				end
			end
			cdd_pkg::ST_MULT:  state_d = cdd_pkg::ST_RESID;
			cdd_pkg::ST_RESID: state_d = year_op ? cdd_pkg::ST_DONE : cdd_pkg::ST_STEP;
			cdd_pkg::ST_STEP: begin
				if (cnt_q == '0) begin
					state_d = cdd_pkg::ST_DONE;
				end
			end
			cdd_pkg::ST_DONE: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = cdd_pkg::ST_IDLE;
				end
			end
			default: state_d = cdd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= s_tuser;
			date_q.day   <= day_in;
			date_q.month <= month_in;
			date_q.year  <= s_tdata[36:21];
			date_q.resid <= 9'd0;
			if (s_tuser == cdd_pkg::OP_WEEKS) begin
				cnt_q <= {n_in, 3'b000} - {3'b000, n_in};
			end else begin
				cnt_q <= {3'b000, n_in};
			end
		end else if (state_q == cdd_pkg::ST_RESID) begin
			if (year_op) begin
				date_q.year <= date_q.year - prod_q[15:0];
			end else begin
				date_q.resid <= r;
			end
		end else if (state_q == cdd_pkg::ST_STEP && cnt_q != '0) begin
			date_q <= date_step;
			cnt_q  <= cnt_q - {{(CNT-1){1'b0}}, 1'b1};
		end
	end

	assign m_tdata = {7'd0, date_q.year, date_q.month, date_q.day};

	// input and output sides are never open together
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("s_tready and m_tvalid both high");

	// calendar state stays in range while stepping
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cdd_pkg::ST_STEP) |-> (date_q.month >= 4'd1 && date_q.month <= 4'd12 &&
		date_q.resid <= cdd_pkg::LAST_RESID && date_q.day != 5'd0))
		else $error("date out of range during stepping");

	// residue agrees with the year's low bits
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cdd_pkg::ST_STEP) |-> (date_q.resid[1:0] == date_q.year[1:0]))
		else $error("year residue out of step with year");

	// an accepted transfer starts the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == cdd_pkg::ST_MULT || state_q == cdd_pkg::ST_DONE))
		else $error("sequencer did not start after accept");

endmodule
